@@ design/nla_pkg.sv @@
// ----------------------------------------------------------------------------
// nla_pkg: shared types and constants for nearest landmark association
// Field widths, request function codes, the stored landmark entry and the
// control word that travels beside the distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package nla_pkg;

   localparam int COORD_W = 20;                 // signed coordinate, 4 fraction bits
   localparam int TAG_W   = 10;                 // landmark identifier
   localparam int FUNC_W  = 2;
   localparam int PROD_W  = 2 * COORD_W;        // one squared term
   localparam int DIST_W  = PROD_W + 1;         // sum of two squared terms

   localparam logic [COORD_W-1:0] RESET_REJECT = COORD_W'(15984);

   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ASSOC = 2'd2;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [TAG_W-1:0]          tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Control word riding along the distance pipeline.
   typedef struct packed {
      logic             valid;
      logic             load_best;   // seed the running minimum with this value
      logic             last;        // final element of the scan
      logic [TAG_W-1:0] tag;
   } ctl_type;

endpackage

`default_nettype wire

@@ design/nearest_landmark_association_unit.sv @@
// ----------------------------------------------------------------------------
// nearest_landmark_association_unit: nearest neighbor landmark association
// Stores up to MAX_LANDMARKS landmarks and returns the identifier of the one
// nearest to an observation, within a programmable rejection distance.
// ----------------------------------------------------------------------------
// A request carries a function code. Clear empties the landmark list and
// returns nothing. Load appends one landmark (position and identifier) and
// returns one response with overflow set if the list was already full.
// Associate scans the stored landmarks in order, one per
// cycle, through a single squared distance unit (subtract, square, add) fed
// from the landmark RAM, and keeps a running minimum seeded with the square
// of reject_distance. The response names the first landmark at the strict
// minimum distance, or reports found = 0 with identifier 0 when none lies
// strictly closer than reject_distance. While an associate request is in
// flight, each stored landmark passes a RAM read, the registered RAM output,
// the three stages of the distance unit and the compare. With an empty list
// only the seed passes the distance unit.
// The request channel stalls while a scan is in flight and while an
// untaken response would be overwritten. Function code three is dropped.
// reject_distance is written over the csr channel while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_landmark_association_unit
   import nla_pkg::*;
#(
   parameter int MAX_LANDMARKS = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request channel
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic        [FUNC_W-1:0]  req_func,
   input  wire logic signed [COORD_W-1:0] req_pos_x,
   input  wire logic signed [COORD_W-1:0] req_pos_y,
   input  wire logic        [TAG_W-1:0]   req_landmark_id,
   // response channel
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic             [TAG_W-1:0]   rsp_matched_id,
   output logic                           rsp_found,
   output logic                           rsp_overflow,
   // configuration write channel
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic        [COORD_W-1:0] csr_data
);

   localparam int ADDR_W = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
   localparam int CNT_W  = $clog2(MAX_LANDMARKS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   logic [1:0]                state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic [COORD_W-1:0]        reject_ff;
   logic signed [COORD_W-1:0] obs_x_ff, obs_y_ff;
   logic                      rd_vld_ff, rd_vld_in;
   logic                      rd_last_ff, rd_last_in;
   logic [DIST_W-1:0]         best_ff, best_in;
   logic                      hit_ff, hit_in;
   logic [TAG_W-1:0]          tag_ff, tag_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [TAG_W-1:0]          rsp_id_ff, rsp_id_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic                      rsp_ovf_ff, rsp_ovf_in;

   logic                      req_accept;
   logic                      list_full;
   logic                      ram_we;
   logic                      ram_re;
   logic [ENTRY_W-1:0]        ram_q;
   entry_type                 wr_entry;
   entry_type                 rd_entry;
   logic                      seed;
   logic                      scan_last;
   logic                      finish;
   ctl_type                   dist_in_ctl;
   ctl_type                   dist_ctl;
   logic [DIST_W-1:0]         dist_val;

   // ---------------------------------------------------------------- handshakes
   // Accept only when idle and the response register is empty or draining.
   assign req_stall  = !((state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = (state_ff == ST_IDLE);

   assign list_full = (cnt_ff == CNT_W'(MAX_LANDMARKS));
   assign scan_last = (idx_ff == cnt_ff - CNT_W'(1));
   assign seed      = req_accept && (req_func == FUNC_ASSOC);
   assign finish    = dist_ctl.valid && dist_ctl.last;

   // ---------------------------------------------------------------- landmark RAM
   assign ram_we         = req_accept && (req_func == FUNC_LOAD) && !list_full;
   assign ram_re         = (state_ff == ST_SCAN);
   assign wr_entry.x     = req_pos_x;
   assign wr_entry.y     = req_pos_y;
   assign wr_entry.tag   = req_landmark_id;
   assign rd_entry       = entry_type'(ram_q);

   nla_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_LANDMARKS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_data (ENTRY_W'(wr_entry)),
      .rd_en   (ram_re),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (ram_q)
   );

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      rd_vld_in  = 1'b0;
      rd_last_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_func)
                  FUNC_CLEAR: begin
                     cnt_in = '0;
                  end
                  FUNC_LOAD: begin
                     if (!list_full) begin
                        cnt_in = cnt_ff + CNT_W'(1);
                     end
                  end
                  FUNC_ASSOC: begin
                     idx_in   = '0;
                     // empty list: only the seed travels, and it closes the scan
                     state_in = (cnt_ff == '0) ? ST_WAIT : ST_SCAN;
                  end
                  default: begin
                     // unused code: drop
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_vld_in  = 1'b1;
            rd_last_in = scan_last;
            idx_in     = idx_ff + CNT_W'(1);
            if (scan_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         idx_ff     <= '0;
         reject_ff  <= RESET_REJECT;
         rd_vld_ff  <= 1'b0;
         rd_last_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         idx_ff     <= idx_in;
         rd_vld_ff  <= rd_vld_in;
         rd_last_ff <= rd_last_in;
         if (csr_valid && csr_ready) begin
            reject_ff <= csr_data;
         end
      end
   end

   // Hold the observation for the length of the scan.
   always_ff @(posedge clock) begin
      if (seed) begin
         obs_x_ff <= req_pos_x;
         obs_y_ff <= req_pos_y;
      end
   end

   // ---------------------------------------------------------------- distance unit
   // The seed enters in the accept cycle, ahead of the first RAM read data.
   always_comb begin
      if (seed) begin
         dist_in_ctl.valid     = 1'b1;
         dist_in_ctl.load_best = 1'b1;
         dist_in_ctl.last      = (cnt_ff == '0);
         dist_in_ctl.tag       = '0;
      end else begin
         dist_in_ctl.valid     = rd_vld_ff;
         dist_in_ctl.load_best = 1'b0;
         dist_in_ctl.last      = rd_last_ff;
         dist_in_ctl.tag       = rd_entry.tag;
      end
   end

   nla_dist u_dist (
      .clock      (clock),
      .reset      (reset),
      .in_ctl     (dist_in_ctl),
      .obs_x      (obs_x_ff),
      .obs_y      (obs_y_ff),
      .ref_x      (rd_entry.x),
      .ref_y      (rd_entry.y),
      .direct_mag (reject_ff),
      .out_ctl    (dist_ctl),
      .out_dist   (dist_val)
   );

   // ---------------------------------------------------------------- running minimum
   // Strict compare keeps the earliest landmark on a tie.
   always_comb begin
      best_in = best_ff;
      hit_in  = hit_ff;
      tag_in  = tag_ff;
      if (dist_ctl.valid) begin
         if (dist_ctl.load_best) begin
            best_in = dist_val;
            hit_in  = 1'b0;
            tag_in  = '0;
         end else if (dist_val < best_ff) begin
            best_in = dist_val;
            hit_in  = 1'b1;
            tag_in  = dist_ctl.tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      hit_ff  <= hit_in;
      tag_ff  <= tag_in;
   end

   // ---------------------------------------------------------------- response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_id_in    = rsp_id_ff;
      rsp_found_in = rsp_found_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (req_accept && (req_func == FUNC_LOAD)) begin
         rsp_valid_in = 1'b1;
         rsp_id_in    = '0;
         rsp_found_in = 1'b0;
         rsp_ovf_in   = list_full;
      end else if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_id_in    = tag_in;
         rsp_found_in = hit_in;
         rsp_ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_id_ff    <= rsp_id_in;
      rsp_found_ff <= rsp_found_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_matched_id = rsp_id_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_overflow   = rsp_ovf_ff;

   // ---------------------------------------------------------------- assertions
   // The scan never reads past the stored landmarks.
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff < cnt_ff))
      else $error("scan index beyond landmark count");

   // The final compare never overwrites a response still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      finish |-> !rsp_valid_ff)
      else $error("association result overwrote a pending response");

   // Nothing is left in the distance pipeline once the block is idle.
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !dist_ctl.valid)
      else $error("distance pipeline busy while idle");

   // The landmark list is never changed during a scan.
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |=> $stable(cnt_ff))
      else $error("landmark count changed during a scan");

endmodule

`default_nettype wire

@@ design/nla_ram.sv @@
// ----------------------------------------------------------------------------
// nla_ram: generic single write port, single read port RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module nla_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ design/nla_dist.sv @@
// ----------------------------------------------------------------------------
// nla_dist: shared squared distance unit
// Three stages: absolute differences, squares, sum. A seed element passes a
// direct magnitude through instead, which yields its square.
// ----------------------------------------------------------------------------
`default_nettype none

module nla_dist
   import nla_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ctl_type                   in_ctl,
   input  wire logic signed [COORD_W-1:0] obs_x,
   input  wire logic signed [COORD_W-1:0] obs_y,
   input  wire logic signed [COORD_W-1:0] ref_x,
   input  wire logic signed [COORD_W-1:0] ref_y,
   input  wire logic        [COORD_W-1:0] direct_mag,
   output ctl_type                        out_ctl,
   output logic             [DIST_W-1:0]  out_dist
);

   ctl_type                  s1_ctl_ff, s2_ctl_ff, s3_ctl_ff;
   logic [COORD_W-1:0]       mag_x_ff, mag_y_ff;
   logic [COORD_W-1:0]       mag_x_in, mag_y_in;
   logic [PROD_W-1:0]        sq_x_ff, sq_y_ff;
   logic [PROD_W-1:0]        sq_x_in, sq_y_in;
   logic [DIST_W-1:0]        dist_ff, dist_in;
   logic signed [COORD_W:0]  diff_x, diff_y;
   logic signed [COORD_W:0]  abs_x, abs_y;

   // Stage 1: magnitudes (a difference of two 20-bit values fits 20 bits unsigned)
   always_comb begin
      diff_x = {obs_x[COORD_W-1], obs_x} - {ref_x[COORD_W-1], ref_x};
      diff_y = {obs_y[COORD_W-1], obs_y} - {ref_y[COORD_W-1], ref_y};
      abs_x  = diff_x[COORD_W] ? -diff_x : diff_x;
      abs_y  = diff_y[COORD_W] ? -diff_y : diff_y;
      if (in_ctl.load_best) begin
         mag_x_in = direct_mag;
         mag_y_in = '0;
      end else begin
         mag_x_in = abs_x[COORD_W-1:0];
         mag_y_in = abs_y[COORD_W-1:0];
      end
   end

   // Stage 2: squares; stage 3: sum
   assign sq_x_in = mag_x_ff * mag_x_ff;
   assign sq_y_in = mag_y_ff * mag_y_ff;
   assign dist_in = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
      end else begin
         s1_ctl_ff <= in_ctl;
         s2_ctl_ff <= s1_ctl_ff;
         s3_ctl_ff <= s2_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      sq_x_ff  <= sq_x_in;
      sq_y_ff  <= sq_y_in;
      dist_ff  <= dist_in;
   end

   assign out_ctl  = s3_ctl_ff;
   assign out_dist = dist_ff;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for nearest_landmark_association_unit
// Streams clear, load and associate requests into the block, predicts each
// response from a private copy of the landmark list and rejection distance,
// and checks every response field by field, in order. Both handshakes idle
// at random; the rejection distance is rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;
   import nla_pkg::*;

   localparam int LANDMARK_SLOTS = 64;
   // Longest associate: one read per slot plus RAM and pipeline latency.
   localparam int SETTLE_CYCLES  = LANDMARK_SLOTS + 36;
   localparam int TIMEOUT        = 6_000_000;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam logic signed [COORD_W-1:0] COORD_MIN = COORD_W'(-524288);
   localparam logic signed [COORD_W-1:0] COORD_MAX = COORD_W'(524287);

   typedef struct {
      logic        [FUNC_W-1:0]  func;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic        [TAG_W-1:0]   id;
      bit                        drain_first;   // hold until every response is back
   } landmark_req_type;

   typedef struct {
      logic [TAG_W-1:0] matched_id;
      logic             found;
      logic             overflow;
   } landmark_answer_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic        [FUNC_W-1:0]  req_func = FUNC_CLEAR;
   logic signed [COORD_W-1:0] req_pos_x = '0;
   logic signed [COORD_W-1:0] req_pos_y = '0;
   logic        [TAG_W-1:0]   req_landmark_id = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic        [TAG_W-1:0]   rsp_matched_id;
   logic                      rsp_found;
   logic                      rsp_overflow;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic        [COORD_W-1:0] csr_data = '0;

   // Requests waiting to be driven, and responses predicted but not yet seen.
   landmark_req_type    queued_requests[$];
   landmark_answer_type landmark_answers[$];

   // Private copy of the block state.
   entry_type          shadow_entries[LANDMARK_SLOTS];
   int                 entry_count = 0;
   logic [COORD_W-1:0] reject_dist = RESET_REJECT;

   // Positions the stimulus believes are stored; used to aim observations.
   longint plan_x[$];
   longint plan_y[$];

   landmark_req_type    cur_req;
   landmark_answer_type seen_want;
   int  gap_left   = 0;
   int  stall_left = 0;
   bit  quiet_mode = 1'b0;   // no idling on either side while set

   int fail_count = 0;
   int n_clear = 0, n_loads = 0, n_dropped = 0, n_assoc = 0, n_found = 0;
   int n_ignored = 0, n_csr = 0, n_checked = 0;

   nearest_landmark_association_unit #(
      .MAX_LANDMARKS(LANDMARK_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_landmark_id(req_landmark_id),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_matched_id(rsp_matched_id),
      .rsp_found(rsp_found),
      .rsp_overflow(rsp_overflow),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Print one line per mismatch and count it.
   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      fail_count++;
   endtask

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_mode)
         return 0;
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
      if (v > longint'(COORD_MAX))
         v = longint'(COORD_MAX);
      if (v < longint'(COORD_MIN))
         v = longint'(COORD_MIN);
      return COORD_W'(v);
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_coord();
      return COORD_W'($urandom);
   endfunction

   // Apply one accepted request to the private landmark list and queue the
   // response it should produce. Association keeps a running minimum seeded
   // with the squared rejection distance; strict less-than keeps the
   // earliest landmark on a tie.
   task automatic landmark_map_step(input landmark_req_type r);
      landmark_answer_type a;
      longint dx, dy, d2, best;
      a = '{matched_id: '0, found: 1'b0, overflow: 1'b0};
      case (r.func)
         FUNC_CLEAR: begin
            entry_count = 0;
            n_clear++;
         end
         FUNC_LOAD: begin
            if (entry_count < LANDMARK_SLOTS) begin
               shadow_entries[entry_count] = '{x: r.x, y: r.y, tag: r.id};
               entry_count++;
            end else begin
               a.overflow = 1'b1;
               n_dropped++;
            end
            n_loads++;
            landmark_answers.insert(landmark_answers.size(), a);
         end
         FUNC_ASSOC: begin
            best = longint'(reject_dist) * longint'(reject_dist);
            for (int j = 0; j < entry_count; j++) begin
               dx = longint'($signed(r.x)) - longint'($signed(shadow_entries[j].x));
               dy = longint'($signed(r.y)) - longint'($signed(shadow_entries[j].y));
               d2 = dx * dx + dy * dy;
               if (d2 < best) begin
                  best = d2;
                  a.found = 1'b1;
                  a.matched_id = shadow_entries[j].tag;
               end
            end
            n_assoc++;
            if (a.found)
               n_found++;
            landmark_answers.insert(landmark_answers.size(), a);
         end
         default: begin
            n_ignored++;
         end
      endcase
   endtask

   // Request driver: advance to the next queued request once the current one
   // is taken, hold the payload while stalled, and insert random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            landmark_map_step(cur_req);
            gap_left = pick_gap();
         end
         if (req_valid && req_stall) begin
            // hold: payload and valid stay as they are
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (queued_requests.size() != 0 &&
                      !(queued_requests[0].drain_first && landmark_answers.size() != 0)) begin
            cur_req = queued_requests.pop_front();
            req_valid       <= 1'b1;
            req_func        <= cur_req.func;
            req_pos_x       <= cur_req.x;
            req_pos_y       <= cur_req.y;
            req_landmark_id <= cur_req.id;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response monitor: compare each taken response with the oldest
   // prediction, then pick the stall for the next cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (landmark_answers.size() == 0) begin
               report_mismatch("response arrived with no request waiting on it");
            end else begin
               seen_want = landmark_answers.pop_front();
               n_checked++;
               if (rsp_matched_id !== seen_want.matched_id)
                  report_mismatch($sformatf("matched_id %0d, predicted %0d",
                                            rsp_matched_id, seen_want.matched_id));
               if (rsp_found !== seen_want.found)
                  report_mismatch($sformatf("found %b, predicted %b",
                                            rsp_found, seen_want.found));
               if (rsp_overflow !== seen_want.overflow)
                  report_mismatch($sformatf("overflow %b, predicted %b",
                                            rsp_overflow, seen_want.overflow));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0)
               stall_left = pick_gap();
         end
      end
   end

   task automatic push_req(input logic [FUNC_W-1:0] func,
                           input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y,
                           input logic [TAG_W-1:0] id,
                           input bit drain_first);
      landmark_req_type r;
      r = '{func: func, x: x, y: y, id: id, drain_first: drain_first};
      queued_requests.insert(queued_requests.size(), r);
      if (func == FUNC_CLEAR) begin
         plan_x.delete();
         plan_y.delete();
      end else if (func == FUNC_LOAD && plan_x.size() < LANDMARK_SLOTS) begin
         plan_x.insert(plan_x.size(), longint'(x));
         plan_y.insert(plan_y.size(), longint'(y));
      end
   endtask

   // Load a landmark: repeat a stored position (tie), drop it near the
   // cluster center, or put it anywhere.
   task automatic push_load(input longint cx, input longint cy, input bit drain);
      int r, k;
      logic signed [COORD_W-1:0] x, y;
      r = $urandom_range(0, 99);
      if (r < 15 && plan_x.size() != 0) begin
         k = $urandom_range(0, plan_x.size() - 1);
         x = COORD_W'(plan_x[k]);
         y = COORD_W'(plan_y[k]);
      end else if (r < 60) begin
         x = clamp_coord(cx + longint'($urandom_range(0, 4096)) - 2048);
         y = clamp_coord(cy + longint'($urandom_range(0, 4096)) - 2048);
      end else begin
         x = rand_coord();
         y = rand_coord();
      end
      push_req(FUNC_LOAD, x, y, TAG_W'($urandom), drain);
   endtask

   // Associate: aim near a stored landmark, with offsets straddling the
   // rejection distance, or look anywhere.
   task automatic push_assoc(input longint cx, input longint cy, input int rej,
                             input bit drain);
      int r, k;
      longint span;
      logic signed [COORD_W-1:0] x, y;
      r = $urandom_range(0, 99);
      span = longint'(rej) + 16;
      if (r < 70 && plan_x.size() != 0) begin
         k = $urandom_range(0, plan_x.size() - 1);
         if (r < 10) begin
            x = COORD_W'(plan_x[k]);
            y = COORD_W'(plan_y[k]);
         end else begin
            x = clamp_coord(plan_x[k] + longint'($urandom_range(0, 2 * span)) - span);
            y = clamp_coord(plan_y[k] + longint'($urandom_range(0, 2 * span)) - span);
         end
      end else if (r < 85) begin
         x = clamp_coord(cx + longint'($urandom_range(0, 8192)) - 4096);
         y = clamp_coord(cy + longint'($urandom_range(0, 8192)) - 4096);
      end else begin
         x = rand_coord();
         y = rand_coord();
      end
      push_req(FUNC_ASSOC, x, y, TAG_W'($urandom), drain);
   endtask

   // Mixed traffic around a random cluster center; small lists keep scans short.
   task automatic random_phase(input int n_items, input int fill_cap);
      int made, pick;
      bit drain;
      longint cx, cy;
      made = 0;
      cx = longint'(rand_coord());
      cy = longint'(rand_coord());
      while (made < n_items) begin
         pick  = $urandom_range(0, 99);
         drain = ($urandom_range(0, 39) == 0);
         if (pick < 4) begin
            push_req(FUNC_CLEAR, rand_coord(), rand_coord(), TAG_W'($urandom), drain);
            made++;
         end else if (pick < 7) begin
            push_req(FUNC_UNUSED, rand_coord(), rand_coord(), TAG_W'($urandom), drain);
         end else if (pick < 50 && plan_x.size() < fill_cap) begin
            push_load(cx, cy, drain);
            made++;
         end else begin
            push_assoc(cx, cy, int'(reject_dist), drain);
            made++;
         end
      end
   endtask

   // Wait until nothing is queued or outstanding, then let a full scan drain.
   task automatic settle_block();
      while (queued_requests.size() != 0 || req_valid || landmark_answers.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reject(input logic [COORD_W-1:0] value);
      settle_block();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      reject_dist = value;
      n_csr++;
   endtask

   initial begin
      #(TIMEOUT);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      longint cx, cy;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty list, ignored code, coordinate extremes, exact hits,
      // out-of-range miss, tie order and the rejection boundary.
      push_req(FUNC_ASSOC, '0, '0, 10'h3FF, 1'b0);
      push_req(FUNC_UNUSED, COORD_MAX, COORD_MIN, 10'h155, 1'b0);
      push_req(FUNC_LOAD, COORD_MIN, COORD_MIN, 10'h000, 1'b0);
      push_req(FUNC_LOAD, COORD_MAX, COORD_MAX, 10'h3FF, 1'b0);
      push_req(FUNC_LOAD, '0, '0, 10'h2AA, 1'b0);
      push_req(FUNC_ASSOC, COORD_W'(1), COORD_W'(-1), 10'h000, 1'b0);
      push_req(FUNC_ASSOC, COORD_MIN, COORD_MIN, 10'h3FF, 1'b0);
      push_req(FUNC_ASSOC, COORD_MAX, COORD_MAX, 10'h000, 1'b0);
      push_req(FUNC_ASSOC, COORD_MAX, COORD_MIN, 10'h000, 1'b0);
      push_req(FUNC_CLEAR, COORD_MAX, COORD_MAX, 10'h3FF, 1'b1);
      push_req(FUNC_LOAD, COORD_W'(160), '0, 10'd7, 1'b0);
      push_req(FUNC_LOAD, COORD_W'(-160), '0, 10'd8, 1'b0);
      push_req(FUNC_LOAD, '0, COORD_W'(160), 10'd9, 1'b0);
      push_req(FUNC_ASSOC, '0, '0, 10'h000, 1'b0);
      push_req(FUNC_ASSOC, COORD_W'(160 + 15984), '0, 10'h000, 1'b0);
      push_req(FUNC_ASSOC, COORD_W'(160 + 15983), '0, 10'h000, 1'b0);
      push_req(FUNC_ASSOC, '0, COORD_W'(160 + 15983), 10'h000, 1'b0);
      push_req(FUNC_UNUSED, '0, '0, 10'h000, 1'b0);
      push_req(FUNC_CLEAR, '0, '0, 10'h000, 1'b0);
      push_req(FUNC_ASSOC, COORD_W'(160), '0, 10'h000, 1'b0);

      random_phase(110, 12);

      // Zero distance rejects everything.
      write_reject('0);
      random_phase(40, 12);

      // Widest distance, no idling on either side.
      write_reject({COORD_W{1'b1}});
      quiet_mode = 1'b1;
      random_phase(60, 12);
      quiet_mode = 1'b0;

      write_reject(COORD_W'($urandom_range(1, 200)));
      random_phase(80, 8);

      // Fill the list past capacity, then search a full list.
      write_reject(COORD_W'($urandom));
      cx = longint'(rand_coord());
      cy = longint'(rand_coord());
      push_req(FUNC_CLEAR, '0, '0, 10'h000, 1'b1);
      repeat (LANDMARK_SLOTS + 4) push_load(cx, cy, 1'b0);
      repeat (10) push_assoc(cx, cy, int'(reject_dist), 1'b0);

      write_reject(COORD_W'($urandom_range(2000, 60000)));
      random_phase(120, 16);

      write_reject(RESET_REJECT);
      random_phase(70, 12);

      settle_block();
      $display("Ran %0d clears, %0d loads (%0d dropped when full), %0d associations",
               n_clear, n_loads, n_dropped, n_assoc);
      $display("%0d associations matched, %0d ignored codes, %0d distance writes, %0d checked",
               n_found, n_ignored, n_csr, n_checked);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ nearest_landmark_association_unit.f @@
design/nla_pkg.sv
design/nla_ram.sv
design/nla_dist.sv
design/nearest_landmark_association_unit.sv
tb/testbench.sv
